@@ src/dlqps_pkg.sv @@
// package for the dual link quality path selector
// holds widths, codes, register indexes and the state machine type; no dependencies
package dlqps_pkg;
  localparam int unsigned WindowSlots = 20;
  localparam int unsigned PathCount = 2;
  localparam int unsigned RttBits = 16;
  localparam int unsigned SlotBits = $clog2(WindowSlots);
  localparam int unsigned RingDepth = PathCount * WindowSlots;
  localparam int unsigned RingAddrBits = $clog2(RingDepth);
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 16;
  localparam logic signed [4:0] StreakMax = 5'sd15;
  localparam logic signed [4:0] StreakBad = 5'sd3;
  localparam logic signed [4:0] StreakGood = -5'sd3;
  localparam logic [6:0] LossMax = 7'd100;

  typedef logic [RttBits-1:0] rtt_t;
  typedef logic [SlotBits-1:0] slot_t;
  typedef logic signed [4:0] streak_t;

  typedef enum logic [1:0] {
    OP_MEASURE = 2'd0,
    OP_USAGE   = 2'd1,
    OP_TICK    = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CAUSE_BAD     = 2'd0,
    CAUSE_GOOD    = 2'd1,
    CAUSE_TIMEOUT = 2'd2
  } cause_e;

  typedef enum logic [2:0] {
    REG_DELAY_BAD    = 3'd0,
    REG_DELAY_GOOD   = 3'd1,
    REG_REL_BAD      = 3'd2,
    REG_REL_GOOD     = 3'd3,
    REG_GRAD_RISE    = 3'd4,
    REG_LOSS_BAD     = 3'd5,
    REG_LOSS_GOOD    = 3'd6,
    REG_TIMEOUT      = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREV1,
    ST_PREV2,
    ST_EVAL,
    ST_RATE
  } state_e;

  function automatic slot_t slot_inc(slot_t s);
    slot_inc = (s == slot_t'(WindowSlots - 1)) ? '0 : slot_t'(s + 1'b1);
  endfunction

  function automatic slot_t slot_dec(slot_t s);
    slot_dec = (s == '0) ? slot_t'(WindowSlots - 1) : slot_t'(s - 1'b1);
  endfunction

  // -1 = good, +1 = bad, 0 = neither
  function automatic streak_t streak_next(streak_t c, logic is_bad, logic is_good);
    if (is_bad) begin
      if (c < 0) streak_next = 5'sd1;
      else if (c < StreakMax) streak_next = c + 5'sd1;
      else streak_next = c;
    end else if (is_good) begin
      if (c > 0) streak_next = -5'sd1;
      else if (c > -StreakMax) streak_next = c - 5'sd1;
      else streak_next = c;
    end else begin
      streak_next = '0;
    end
  endfunction
endpackage

@@ src/dlqps_ram.sv @@
// generic single port synchronous ram with registered read
// no dependencies
module dlqps_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 40
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ src/dual_link_quality_path_selector_unit.sv @@
// top level of the dual link quality path selector
// uses dlqps_pkg and dlqps_ram for the per-path rtt windows
//
// channel  | dir | handshake          | payload
// cfg      | in  | cfg_valid/ready    | cfg_index, cfg_data
// in       | in  | in_valid/ready     | opcode, path_index, rtt_ms, loss_pct, usage_mask
// out      | out | out_valid/ready    | wanted_paths, cause
//
// usage, tick and ignored words run no state walk; a timeout word holds in_ready low until it leaves
// a measurement keeps in_ready low while it walks scan (full window only, one ram read per
// slot of the 20-slot walk), prev1, prev2, eval and rate; its result word is registered in rate
// the single ring ram port sets the measurement time; no clearing pass after reset
// in_ready drops while a measurement runs or a word waits in the output register
module dual_link_quality_path_selector_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dlqps_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [dlqps_pkg::CfgDataBits-1:0]  cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         opcode_i,
  input  logic                               path_index_i,
  input  logic [dlqps_pkg::RttBits-1:0]      rtt_ms_i,
  input  logic [6:0]                         loss_pct_i,
  input  logic [1:0]                         usage_mask_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         wanted_paths_o,
  output logic [1:0]                         cause_o
);
  import dlqps_pkg::*;

  logic [15:0] delay_bad_q, delay_good_q, rel_bad_q, rel_good_q, grad_rise_q, timeout_q;
  logic [6:0]  loss_bad_q, loss_good_q;

  slot_t       head_q [PathCount];
  slot_t       tail_q [PathCount];
  streak_t     cnt_q [PathCount][4];
  logic [15:0] timer_q [PathCount];
  logic [PathCount-1:0] in_use_q;
  logic [1:0]  expected_q;

  state_e state_q, state_d;
  logic   path_q;
  rtt_t   rtt_q;
  logic [6:0] loss_q;
  slot_t  idx_q, idx_d;
  rtt_t   min_q;
  logic   full_q;
  rtt_t   prev1_q;
  logic   out_valid_q;
  logic [1:0] out_wanted_q, out_cause_q;

  logic   ram_we;
  logic [RingAddrBits-1:0] ram_addr;
  rtt_t   ram_rdata;
  slot_t  ram_slot;
  logic   rd_pend_q;
  logic   in_acc;

  logic [15:0] arm_val;
  assign arm_val = (timeout_q == '0) ? 16'd1 : timeout_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE) && !out_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign wanted_paths_o = out_wanted_q;
  assign cause_o     = out_cause_q;

  // ring geometry for the current measurement
  slot_t cur_head, cur_tail, new_head;
  logic [SlotBits:0] fill_cnt;
  logic  has_grad;
  assign cur_head = head_q[path_q];
  assign cur_tail = tail_q[path_q];
  assign new_head = full_q ? slot_inc(cur_head) : cur_head;
  assign fill_cnt = (cur_tail >= new_head) ?
                    {1'b0, cur_tail} - {1'b0, new_head} :
                    {1'b0, cur_tail} + (SlotBits+1)'(WindowSlots) - {1'b0, new_head};
  assign has_grad = fill_cnt > (SlotBits+1)'(2);

  dlqps_ram #(.Width(RttBits), .Depth(RingDepth)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (rtt_ms_i),
    .rdata_o (ram_rdata)
  );

  logic ram_path;
  always_comb begin
    ram_we   = 1'b0;
    ram_path = path_q;
    ram_slot = idx_q;
    if (state_q == ST_IDLE) begin
      ram_path = path_index_i;
      ram_slot = tail_q[path_index_i];
      ram_we   = in_acc && (opcode_e'(opcode_i) == OP_MEASURE) &&
                 in_use_q[path_index_i] && (loss_pct_i <= LossMax);
    end
    ram_addr = RingAddrBits'(ram_path) * RingAddrBits'(WindowSlots) +
               RingAddrBits'(ram_slot);
  end

  logic start_meas;
  assign start_meas = ram_we;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (start_meas) begin
          if (slot_inc(tail_q[path_index_i]) == head_q[path_index_i]) begin
            state_d = ST_SCAN;
            idx_d   = head_q[path_index_i];
          end else begin
            state_d = ST_PREV1;
            idx_d   = slot_dec(tail_q[path_index_i]);
          end
        end
      end
      ST_SCAN: begin
        if (idx_q == cur_tail) begin
          state_d = ST_PREV1;
          idx_d   = slot_dec(cur_tail);
        end else begin
          idx_d = slot_inc(idx_q);
        end
      end
      ST_PREV1: begin
        state_d = ST_PREV2;
        idx_d   = slot_dec(idx_q);
      end
      ST_PREV2: state_d = ST_EVAL;
      ST_EVAL:  state_d = ST_RATE;
      ST_RATE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // evaluation (registered between eval and rate)
  logic signed [RttBits+1:0] rel_d, grad_d, lgrad_d;
  always_comb begin
    rel_d   = full_q ? $signed({2'b00, rtt_q}) - $signed({2'b00, min_q}) : '0;
    grad_d  = has_grad ? $signed({2'b00, rtt_q}) - $signed({2'b00, prev1_q}) : '0;
    lgrad_d = has_grad ? $signed({2'b00, prev1_q}) - $signed({2'b00, ram_rdata}) : '0;
  end

  logic signed [RttBits+1:0] rel_q, grad_q, lgrad_q;
  streak_t c_new [4];
  logic rise, bad, good, both;
  always_comb begin
    c_new[0] = streak_next(cnt_q[path_q][0], rtt_q >= delay_bad_q, rtt_q < delay_good_q);
    c_new[1] = streak_next(cnt_q[path_q][1],
                           rel_q >= $signed({2'b00, rel_bad_q}),
                           rel_q < $signed({2'b00, rel_good_q}));
    c_new[2] = streak_next(cnt_q[path_q][2], grad_q > 0, grad_q < 0);
    c_new[3] = streak_next(cnt_q[path_q][3], loss_q >= loss_bad_q, loss_q < loss_good_q);
    rise = (grad_q > $signed({2'b00, grad_rise_q})) &&
           (lgrad_q > $signed({2'b00, grad_rise_q})) && (grad_q > lgrad_q);
    bad  = rise || c_new[0] >= StreakBad || c_new[1] >= StreakBad ||
           c_new[2] >= StreakBad || c_new[3] >= StreakBad;
    good = c_new[0] <= StreakGood && c_new[1] <= StreakGood && c_new[3] <= StreakGood;
    both = &in_use_q;
  end

  logic fired;
  always_comb begin
    fired = 1'b0;
    for (int q = 0; q < PathCount; q++) begin
      if (timer_q[q] == 16'd1) fired = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      delay_bad_q <= 16'd80;
      delay_good_q <= 16'd60;
      rel_bad_q <= 16'd20;
      rel_good_q <= 16'd10;
      grad_rise_q <= 16'd5;
      loss_bad_q <= 7'd6;
      loss_good_q <= 7'd4;
      timeout_q <= 16'd5000;
      in_use_q <= '0;
      expected_q <= '0;
      out_valid_q <= 1'b0;
      out_wanted_q <= '0;
      out_cause_q <= '0;
      rd_pend_q <= 1'b0;
      for (int q = 0; q < PathCount; q++) begin
        head_q[q] <= '0;
        tail_q[q] <= '0;
        timer_q[q] <= '0;
        for (int k = 0; k < 4; k++) cnt_q[q][k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        case (reg_e'(cfg_index_i))
          REG_DELAY_BAD:  delay_bad_q <= cfg_data_i;
          REG_DELAY_GOOD: delay_good_q <= cfg_data_i;
          REG_REL_BAD:    rel_bad_q <= cfg_data_i;
          REG_REL_GOOD:   rel_good_q <= cfg_data_i;
          REG_GRAD_RISE:  grad_rise_q <= cfg_data_i;
          REG_LOSS_BAD:   loss_bad_q <= cfg_data_i[6:0];
          REG_LOSS_GOOD:  loss_good_q <= cfg_data_i[6:0];
          REG_TIMEOUT:    timeout_q <= cfg_data_i;
          default: ;
        endcase
      end
      rd_pend_q <= (state_q == ST_SCAN);
      if (in_acc) begin
        case (opcode_e'(opcode_i))
          OP_MEASURE: begin
            if (start_meas) timer_q[path_index_i] <= arm_val;
          end
          OP_USAGE: begin
            for (int q = 0; q < PathCount; q++) begin
              if (usage_mask_i[q] != in_use_q[q]) begin
                if (usage_mask_i[q]) begin
                  timer_q[q] <= arm_val;
                end else begin
                  timer_q[q] <= '0;
                  head_q[q] <= '0;
                  tail_q[q] <= '0;
                  for (int k = 0; k < 4; k++) cnt_q[q][k] <= '0;
                end
              end
            end
            in_use_q <= usage_mask_i;
            expected_q <= '0;
          end
          OP_TICK: begin
            for (int q = 0; q < PathCount; q++) begin
              if (timer_q[q] != '0) timer_q[q] <= timer_q[q] - 16'd1;
            end
            if (fired && !(&in_use_q)) begin
              expected_q <= 2'd3;
              out_valid_q <= 1'b1;
              out_wanted_q <= 2'd3;
              out_cause_q <= CAUSE_TIMEOUT;
            end
          end
          default: ;
        endcase
      end
      if (state_q == ST_RATE) begin
        head_q[path_q] <= new_head;
        tail_q[path_q] <= slot_inc(cur_tail);
        for (int k = 0; k < 4; k++) cnt_q[path_q][k] <= c_new[k];
        if (good) begin
          if (both) begin
            expected_q <= path_q ? 2'd2 : 2'd1;
            out_valid_q <= 1'b1;
            out_wanted_q <= path_q ? 2'd2 : 2'd1;
            out_cause_q <= CAUSE_GOOD;
          end
        end else if (bad && !both) begin
          expected_q <= 2'd3;
          out_valid_q <= 1'b1;
          out_wanted_q <= 2'd3;
          out_cause_q <= CAUSE_BAD;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (state_q == ST_IDLE && start_meas) begin
      path_q <= path_index_i;
      rtt_q  <= rtt_ms_i;
      loss_q <= loss_pct_i;
      full_q <= slot_inc(tail_q[path_index_i]) == head_q[path_index_i];
      min_q  <= '1;
    end
    // scan folds head..tail-1 into min_q; read data arrives in the cycle after its address
    if (rd_pend_q && state_q == ST_SCAN && ram_rdata < min_q)
      min_q <= ram_rdata;
    if (state_q == ST_PREV2) prev1_q <= ram_rdata;
    if (state_q == ST_EVAL) begin
      rel_q   <= rel_d;
      grad_q  <= grad_d;
      lgrad_q <= lgrad_d;
    end
  end
endmodule
